// ----- rtl/core/srm_pkg.sv -----
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants of the sphere ray march shader
// Register indexes, reset values, palette limits and unit status type.
// ----------------------------------------------------------------------------
package srm_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } srm_unit_sts_t;

  typedef enum logic [2:0] {
    REG_MAX_DEPTH     = 3'd0,
    REG_HIT_THRESHOLD = 3'd1,
    REG_NORMAL_OFFSET = 3'd2,
    REG_MAX_STEPS     = 3'd3,
    REG_SPHERE_RADIUS = 3'd4,
    REG_CAMERA_Z      = 3'd5
  } srm_reg_t;

  localparam logic [15:0] RST_MAX_DEPTH     = 16'd25600;
  localparam logic [15:0] RST_HIT_THRESHOLD = 16'd1678;
  localparam logic [15:0] RST_NORMAL_OFFSET = 16'd1678;
  localparam logic [7:0]  RST_MAX_STEPS     = 8'd200;
  localparam logic [14:0] RST_SPHERE_RADIUS = 15'd4096;
  localparam logic [14:0] RST_CAMERA_Z      = 15'd4121;

  localparam logic [63:0] PAL_LEVELS = 64'd27;
  localparam logic [63:0] SHADE_MAX  = 64'd26;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ----- rtl/core/sphere_ray_march_shader.sv -----
// ----------------------------------------------------------------------------
// sphere_ray_march_shader: per-pixel sphere tracer with diffuse palette shade
// Sequencer over one shared multiplier, square-root unit and divider.
// ----------------------------------------------------------------------------
// Usage: write the six registers on the cfg_ port while idle. Send one pixel
// (screen_x, screen_y) on in_; one result (hit, shade, distance, steps_used)
// comes back on out_ for every pixel, in order.
// One pixel at a time: in_tready is high only while idle. A pixel runs
// the ray direction normalize (three products, one root, three divides),
// each march step (three ray products, three squares, one root), and on a
// hit six gradient lengths and two more normalizes. The root and the
// divider produce one bit per cycle.
// The result is held on out_tdata with out_tvalid high until out_tready;
// no new pixel is taken meanwhile. Reset clears the sequencer and loads the
// register defaults; nothing else needs clearing.
// ----------------------------------------------------------------------------
module sphere_ray_march_shader
  import srm_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: screen_x[15:0], screen_y[31:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata: hit[0], shade[5:1], distance[21:6], steps_used[29:22], zero[31:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO_Q    = ONE_Q << 1;
  localparam logic [63:0] NORM_MIN = (64'd1 << FRAC_BITS) / 64'd100000;
  localparam int IN_SH = FRAC_BITS - 14;
  localparam int EPS_L = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int EPS_R = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_SQ   = 13'b0000000000010,
    ST_SQRT = 13'b0000000000100,
    ST_DIV  = 13'b0000000001000,
    ST_DIR  = 13'b0000000010000,
    ST_RP   = 13'b0000000100000,
    ST_STEP = 13'b0000001000000,
    ST_GRAD = 13'b0000010000000,
    ST_GACC = 13'b0000100000000,
    ST_NRM  = 13'b0001000000000,
    ST_DOT  = 13'b0010000000000,
    ST_FIN  = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, ret_r;

  logic [15:0] max_depth_r, hit_thr_r, nrm_off_r;
  logic [7:0]  max_steps_r;
  logic [14:0] radius_r, cam_z_r;

  logic signed [63:0] vec_r [3];
  logic signed [63:0] res_r [3];
  logic signed [63:0] dir_r [3];
  logic signed [63:0] p_r   [3];
  logic signed [63:0] g_r   [3];
  logic signed [63:0] nrm_r [3];
  logic signed [63:0] len_r, t_r, plus_r, diff_r;
  logic [127:0]       sum_r;
  logic [7:0]         n_r;
  logic [1:0]         k_r;
  logic [2:0]         j_r;
  logic               pend_r, norm_r, shade_ph_r;

  logic        out_hit_r;
  logic [4:0]  out_shade_r;
  logic [15:0] out_dist_r;
  logic [7:0]  out_steps_r;

  // derived constants from the registers
  logic signed [63:0] cz, rad, md, eps, e_off;
  assign cz    = {49'd0, cam_z_r} << (FRAC_BITS - 12);
  assign rad   = {49'd0, radius_r} << (FRAC_BITS - 12);
  assign md    = {48'd0, max_depth_r} << (FRAC_BITS - 8);
  assign eps   = ({48'd0, hit_thr_r} << EPS_L) >> EPS_R;
  assign e_off = ({48'd0, nrm_off_r} << EPS_L) >> EPS_R;

  // shared units
  srm_unit_sts_t mul_sts, sqrt_sts, div_sts;
  logic          mul_start, sqrt_start, div_start;
  logic [63:0]   mul_a, mul_b, sqrt_root, div_q;
  logic [127:0]  mul_prod;
  logic          q_neg;
  logic [63:0]   qm;
  logic signed [63:0] qm_s, div_s, len_d, t_new;
  logic [7:0]    n_new;
  logic [1:0]    gi;

  always_comb begin
    case (state_r)
      ST_RP: begin
        mul_a = mag64(dir_r[k_r]);
        mul_b = mag64(t_r);
        q_neg = dir_r[k_r][63] ^ t_r[63];
      end
      ST_DOT: begin
        mul_a = mag64(res_r[k_r]);
        mul_b = mag64(nrm_r[k_r]);
        q_neg = res_r[k_r][63] ^ nrm_r[k_r][63];
      end
      default: begin
        mul_a = mag64(vec_r[k_r]);
        mul_b = mag64(vec_r[k_r]);
        q_neg = 1'b0;
      end
    endcase
  end

  assign mul_start  = (state_r == ST_SQ || state_r == ST_RP || state_r == ST_DOT) && !pend_r;
  assign sqrt_start = (state_r == ST_SQRT) && !pend_r;
  assign div_start  = (state_r == ST_DIV) && !pend_r && (len_r > $signed(NORM_MIN));

  // truncate magnitude product to Q.F, then apply sign
  assign qm    = {1'b0, mul_prod[FRAC_BITS+62 -: 63]};
  assign qm_s  = q_neg ? -$signed(qm) : $signed(qm);
  assign div_s = vec_r[k_r][63] ? -$signed(div_q) : $signed(div_q);
  assign len_d = len_r - rad;
  assign t_new = t_r + len_d;
  assign n_new = n_r + 8'd1;
  assign gi    = j_r[2:1];

  srm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  srm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sum_r),
    .sts   (sqrt_sts),
    .root  (sqrt_root)
  );

  srm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag64(vec_r[k_r])),
    .den   (len_r),
    .sts   (div_sts),
    .quo   (div_q)
  );

  // output shading and distance
  logic signed [63:0] dc;
  logic [63:0]        p27, sf, tsh;
  logic [4:0]         shade_c;
  logic [15:0]        dist_c;

  always_comb begin
    if (diff_r < 0) begin
      dc = 64'sd0;
    end else if (diff_r > $signed(ONE_Q)) begin
      dc = $signed(ONE_Q);
    end else begin
      dc = diff_r;
    end
    p27 = dc * PAL_LEVELS;
    sf  = p27 >> FRAC_BITS;
    shade_c = (sf > SHADE_MAX) ? SHADE_MAX[4:0] : sf[4:0];
    tsh = t_r >> (FRAC_BITS - 8);
    if (t_r < 0) begin
      dist_c = 16'd0;
    end else if (tsh > 64'd65535) begin
      dist_c = 16'hFFFF;
    end else begin
      dist_c = tsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      pend_r      <= 1'b0;
      max_depth_r <= RST_MAX_DEPTH;
      hit_thr_r   <= RST_HIT_THRESHOLD;
      nrm_off_r   <= RST_NORMAL_OFFSET;
      max_steps_r <= RST_MAX_STEPS;
      radius_r    <= RST_SPHERE_RADIUS;
      cam_z_r     <= RST_CAMERA_Z;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAX_DEPTH:     max_depth_r <= cfg_wdata;
          REG_HIT_THRESHOLD: hit_thr_r   <= cfg_wdata;
          REG_NORMAL_OFFSET: nrm_off_r   <= cfg_wdata;
          REG_MAX_STEPS:     max_steps_r <= cfg_wdata[7:0];
          REG_SPHERE_RADIUS: radius_r    <= cfg_wdata[14:0];
          REG_CAMERA_Z:      cam_z_r     <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            vec_r[0] <= {{48{in_tdata[15]}}, in_tdata[15:0]} << IN_SH;
            vec_r[1] <= {{48{in_tdata[31]}}, in_tdata[31:16]} << IN_SH;
            vec_r[2] <= -$signed(ONE_Q);
            norm_r   <= 1'b1;
            ret_r    <= ST_DIR;
            sum_r    <= 128'd0;
            k_r      <= 2'd0;
            state_r  <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (mul_sts.done) begin
            pend_r <= 1'b0;
            sum_r  <= sum_r + mul_prod;
            if (k_r == 2'd2) begin
              k_r     <= 2'd0;
              state_r <= ST_SQRT;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (sqrt_sts.done) begin
            pend_r  <= 1'b0;
            len_r   <= {1'b0, sqrt_root[62:0]};
            k_r     <= 2'd0;
            state_r <= norm_r ? ST_DIV : ret_r;
          end
        end
        ST_DIV: begin
          if (len_r <= $signed(NORM_MIN)) begin
            // too short to normalize: zero vector
            for (int c = 0; c < 3; c++) begin
              res_r[c] <= 64'sd0;
            end
            state_r <= ret_r;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (div_sts.done) begin
            pend_r     <= 1'b0;
            res_r[k_r] <= div_s;
            if (k_r == 2'd2) begin
              k_r     <= 2'd0;
              state_r <= ret_r;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        ST_DIR: begin
          for (int c = 0; c < 3; c++) begin
            dir_r[c] <= res_r[c];
          end
          t_r        <= 64'sd0;
          n_r        <= 8'd0;
          diff_r     <= 64'sd0;
          k_r        <= 2'd0;
          // no steps allowed: t stays 0, which is always a hit
          shade_ph_r <= (max_steps_r == 8'd0);
          state_r    <= ST_RP;
        end
        ST_RP: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (mul_sts.done) begin
            pend_r <= 1'b0;
            if (k_r == 2'd2) begin
              p_r[2] <= cz + qm_s;
              k_r    <= 2'd0;
              if (shade_ph_r) begin
                j_r     <= 3'd0;
                state_r <= ST_GRAD;
              end else begin
                vec_r[0] <= p_r[0];
                vec_r[1] <= p_r[1];
                vec_r[2] <= cz + qm_s;
                norm_r   <= 1'b0;
                ret_r    <= ST_STEP;
                sum_r    <= 128'd0;
                state_r  <= ST_SQ;
              end
            end else begin
              p_r[k_r] <= qm_s;
              k_r      <= k_r + 2'd1;
            end
          end
        end
        ST_STEP: begin
          t_r <= t_new;
          n_r <= n_new;
          k_r <= 2'd0;
          if (len_d < eps || t_new > md || n_new == max_steps_r) begin
            if (t_new <= md) begin
              shade_ph_r <= 1'b1;
              state_r    <= ST_RP;
            end else begin
              state_r <= ST_FIN;
            end
          end else begin
            state_r <= ST_RP;
          end
        end
        ST_GRAD: begin
          for (int c = 0; c < 3; c++) begin
            if (2'(c) == gi) begin
              vec_r[c] <= j_r[0] ? (p_r[c] - e_off) : (p_r[c] + e_off);
            end else begin
              vec_r[c] <= p_r[c];
            end
          end
          norm_r  <= 1'b0;
          ret_r   <= ST_GACC;
          sum_r   <= 128'd0;
          k_r     <= 2'd0;
          state_r <= ST_SQ;
        end
        ST_GACC: begin
          if (!j_r[0]) begin
            plus_r  <= len_d;
            j_r     <= j_r + 3'd1;
            state_r <= ST_GRAD;
          end else begin
            g_r[gi] <= plus_r - len_d;
            if (j_r == 3'd5) begin
              vec_r[0] <= g_r[0];
              vec_r[1] <= g_r[1];
              vec_r[2] <= plus_r - len_d;
              norm_r   <= 1'b1;
              ret_r    <= ST_NRM;
              sum_r    <= 128'd0;
              k_r      <= 2'd0;
              state_r  <= ST_SQ;
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= ST_GRAD;
            end
          end
        end
        ST_NRM: begin
          for (int c = 0; c < 3; c++) begin
            nrm_r[c] <= res_r[c];
          end
          vec_r[0] <= $signed(ONE_Q) - p_r[0];
          vec_r[1] <= $signed(ONE_Q) - p_r[1];
          vec_r[2] <= $signed(TWO_Q) - p_r[2];
          norm_r   <= 1'b1;
          ret_r    <= ST_DOT;
          sum_r    <= 128'd0;
          k_r      <= 2'd0;
          state_r  <= ST_SQ;
        end
        ST_DOT: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (mul_sts.done) begin
            pend_r <= 1'b0;
            diff_r <= diff_r + qm_s;
            if (k_r == 2'd2) begin
              k_r     <= 2'd0;
              state_r <= ST_FIN;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        ST_FIN: begin
          out_hit_r   <= (t_r <= md);
          out_shade_r <= (t_r <= md) ? shade_c : 5'd0;
          out_dist_r  <= dist_c;
          out_steps_r <= n_r;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {2'b00, out_steps_r, out_dist_r, out_shade_r, out_hit_r};

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_miss_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[5:1] == 5'd0))
    else $error("shade set on a miss");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:1] <= 5'd26))
    else $error("shade beyond palette");

  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && (sqrt_sts.busy || div_sts.busy)))
    else $error("shared units overlap");

endmodule

// ----- rtl/core/srm_mul.sv -----
// ----------------------------------------------------------------------------
// srm_mul: 64x64 unsigned multiplier
// One 32x32 partial product per cycle, accumulated into a 128-bit sum.
// ----------------------------------------------------------------------------
module srm_mul
  import srm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output srm_unit_sts_t sts,
  output logic [127:0]  prod
);

  logic [63:0]  a_r, b_r, pp_r;
  logic [2:0]   cnt_r;
  logic [1:0]   sh_r;
  logic         run_r, pv_r, done_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp_c;
  logic [127:0] pp_sh;

  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp_c   = a_half * b_half;

  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        cnt_r <= 3'd0;
        run_r <= 1'b1;
        pv_r  <= 1'b0;
        acc_r <= 128'd0;
      end else if (run_r) begin
        if (cnt_r != 3'd4) begin
          pp_r  <= pp_c;
          sh_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
          pv_r  <= 1'b1;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          pv_r   <= 1'b0;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        if (pv_r) begin
          acc_r <= acc_r + pp_sh;
        end
      end
    end
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

// ----- rtl/core/srm_sqrt.sv -----
// ----------------------------------------------------------------------------
// srm_sqrt: integer square root
// Floor root of a 128-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module srm_sqrt
  import srm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [127:0]  rad,
  output srm_unit_sts_t sts,
  output logic [63:0]   root
);

  logic [127:0] rad_r;
  logic [67:0]  rem_r, rem_sh, trial;
  logic [63:0]  root_r;
  logic [6:0]   cnt_r;
  logic         run_r, done_r;

  assign rem_sh = {rem_r[65:0], rad_r[127:126]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= 68'd0;
        root_r <= 64'd0;
        cnt_r  <= 7'd0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (cnt_r != 7'd64) begin
          rad_r <= {rad_r[125:0], 2'b00};
          cnt_r <= cnt_r + 7'd1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[62:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[62:0], 1'b0};
          end
        end else begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

// ----- rtl/core/srm_div.sv -----
// ----------------------------------------------------------------------------
// srm_div: fractional divider
// Low 64 bits of (num << FRAC_BITS) / den, restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module srm_div
  import srm_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   num,
  input  logic [63:0]   den,
  output srm_unit_sts_t sts,
  output logic [63:0]   quo
);

  localparam int DW = 64 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_r;
  logic [63:0]   rem_r, den_r, q_r;
  logic [64:0]   rs;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;

  assign rs = {rem_r, dvd_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= {num, {FRAC_BITS{1'b0}}};
        den_r <= den;
        rem_r <= 64'd0;
        q_r   <= 64'd0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (cnt_r != CW'(DW)) begin
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          cnt_r <= cnt_r + CW'(1);
          if (rs >= {1'b0, den_r}) begin
            rem_r <= 64'(rs - {1'b0, den_r});
            q_r   <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= rs[63:0];
            q_r   <= {q_r[62:0], 1'b0};
          end
        end else begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

// ----- bench/tb_sphere_ray_march_shader.sv -----
// ----------------------------------------------------------------------------
// tb_sphere_ray_march_shader: self-checking bench for the sphere ray marcher
// Streams screen coordinates through several register settings with random
// gaps and output stalls, predicts hit, shade, distance and step count with
// a bit-exact fixed point model and compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb_sphere_ray_march_shader;
  import srm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 24;
  localparam logic [63:0] NORM_FLOOR = 64'd167;  // 2^24 / 100000

  typedef logic signed [63:0] s64_t;
  typedef logic [63:0] u64_t;
  typedef s64_t vec3_t [3];

  typedef struct packed {
    logic        hit;
    logic [4:0]  shade;
    logic [15:0] distance;
    logic [7:0]  steps_used;
  } pix_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // register copies used by the shading model
  logic [15:0] r_max_depth = RST_MAX_DEPTH;
  logic [15:0] r_hit_thr   = RST_HIT_THRESHOLD;
  logic [15:0] r_nrm_off   = RST_NORMAL_OFFSET;
  logic [7:0]  r_max_steps = RST_MAX_STEPS;
  logic [14:0] r_radius    = RST_SPHERE_RADIUS;
  logic [14:0] r_cam_z     = RST_CAMERA_Z;

  logic [31:0] pixel_q[$];
  pix_res_t    shade_q[$];
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 0;
  int          errors = 0;

  sphere_ray_march_shader DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic u64_t mag(s64_t v);
    return v[63] ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic s64_t fx_mul(s64_t a, s64_t b);
    logic [127:0] p;
    u64_t r;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    r = p[FB +: 64];
    r[63] = 1'b0;
    return (a[63] != b[63]) ? -s64_t'(r) : s64_t'(r);
  endfunction

  function automatic s64_t vec_len(s64_t x, s64_t y, s64_t z);
    logic [127:0] sum, c2;
    u64_t root, c;
    sum = {64'd0, mag(x)} * {64'd0, mag(x)} + {64'd0, mag(y)} * {64'd0, mag(y)}
        + {64'd0, mag(z)} * {64'd0, mag(z)};
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      c = root | (u64_t'(1) << i);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= sum) root = c;
    end
    root[63] = 1'b0;
    return s64_t'(root);
  endfunction

  function automatic void normalize(input vec3_t v, output vec3_t o);
    s64_t len;
    logic [127:0] q;
    len = vec_len(v[0], v[1], v[2]);
    for (int i = 0; i < 3; i++) begin
      if (u64_t'(len) <= NORM_FLOOR) o[i] = '0;
      else begin
        q = ({64'd0, mag(v[i])} << FB) / {64'd0, u64_t'(len)};
        o[i] = v[i][63] ? -s64_t'(q[63:0]) : s64_t'(q[63:0]);
      end
    end
  endfunction

  function automatic pix_res_t shade_pixel(logic [31:0] px);
    vec3_t v, dir, p, q, g, nrm, ld, ldir;
    s64_t cz, rad, md, eps, e, t, d, diff, plus, minus;
    logic [7:0] n;
    u64_t sh, dst;
    pix_res_t r;
    cz   = s64_t'({49'd0, r_cam_z}) <<< 12;
    rad  = s64_t'({49'd0, r_radius}) <<< 12;
    md   = s64_t'({48'd0, r_max_depth}) <<< 16;
    eps  = s64_t'({48'd0, r_hit_thr});
    e    = s64_t'({48'd0, r_nrm_off});
    v[0] = s64_t'($signed(px[15:0])) <<< 10;
    v[1] = s64_t'($signed(px[31:16])) <<< 10;
    v[2] = -(s64_t'(1) <<< FB);
    normalize(v, dir);
    t = '0;
    n = '0;
    while (n < r_max_steps) begin
      p[0] = fx_mul(dir[0], t);
      p[1] = fx_mul(dir[1], t);
      p[2] = cz + fx_mul(dir[2], t);
      d = vec_len(p[0], p[1], p[2]) - rad;
      t = t + d;
      n++;
      if (d < eps) break;
      if (t > md) break;
    end
    r.hit = (t <= md);
    sh = '0;
    if (r.hit) begin
      p[0] = fx_mul(dir[0], t);
      p[1] = fx_mul(dir[1], t);
      p[2] = cz + fx_mul(dir[2], t);
      for (int i = 0; i < 3; i++) begin
        q = p;
        q[i] = p[i] + e;
        plus = vec_len(q[0], q[1], q[2]) - rad;
        q[i] = p[i] - e;
        minus = vec_len(q[0], q[1], q[2]) - rad;
        g[i] = plus - minus;
      end
      normalize(g, nrm);
      ld[0] = (s64_t'(1) <<< FB) - p[0];
      ld[1] = (s64_t'(1) <<< FB) - p[1];
      ld[2] = (s64_t'(2) <<< FB) - p[2];
      normalize(ld, ldir);
      diff = '0;
      for (int i = 0; i < 3; i++) diff += fx_mul(ldir[i], nrm[i]);
      if (diff < 0) diff = '0;
      if (diff > (s64_t'(1) <<< FB)) diff = s64_t'(1) <<< FB;
      sh = (u64_t'(diff) * PAL_LEVELS) >> FB;
      if (sh > SHADE_MAX) sh = SHADE_MAX;
    end
    if (t < 0) dst = '0;
    else begin
      dst = u64_t'(t) >> (FB - 8);
      if (dst > 64'hFFFF) dst = 64'hFFFF;
    end
    r.shade      = sh[4:0];
    r.distance   = dst[15:0];
    r.steps_used = n;
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: predict on each accepted pixel, then advance the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) shade_q.push_back(shade_pixel(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_tdata <= pixel_q.pop_front();
          in_tvalid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each result transfer
  always @(posedge clk) begin
    pix_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[5:1], out_tdata[21:6], out_tdata[29:22]};
        if (shade_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          errors++;
        end else begin
          want = shade_q.pop_front();
          if (got.hit != want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, got.hit);
            errors++;
          end
          if (got.shade != want.shade) begin
            $error("shade: expected %0d actual %0d", want.shade, got.shade);
            errors++;
          end
          if (got.distance != want.distance) begin
            $error("distance: expected %0d actual %0d", want.distance, got.distance);
            errors++;
          end
          if (got.steps_used != want.steps_used) begin
            $error("steps_used: expected %0d actual %0d", want.steps_used,
                   got.steps_used);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) out_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(srm_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MAX_DEPTH:     r_max_depth = val;
      REG_HIT_THRESHOLD: r_hit_thr   = val;
      REG_NORMAL_OFFSET: r_nrm_off   = val;
      REG_MAX_STEPS:     r_max_steps = val[7:0];
      REG_SPHERE_RADIUS: r_radius    = val[14:0];
      REG_CAMERA_Z:      r_cam_z     = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] md, logic [15:0] thr, logic [15:0] off,
                          logic [7:0] steps, logic [14:0] rad, logic [14:0] cz);
    write_reg(REG_MAX_DEPTH, md);
    write_reg(REG_HIT_THRESHOLD, thr);
    write_reg(REG_NORMAL_OFFSET, off);
    write_reg(REG_MAX_STEPS, {8'd0, steps});
    write_reg(REG_SPHERE_RADIUS, {1'b0, rad});
    write_reg(REG_CAMERA_Z, {1'b0, cz});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_pixel(logic [15:0] x, logic [15:0] y);
    pixel_q.push_back({y, x});
  endtask

  // mostly rays that can reach the sphere, the rest anywhere on the screen
  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0)
        push_pixel(16'($signed($urandom_range(0, 24000)) - 12000),
                   16'($signed($urandom_range(0, 24000)) - 12000));
      else
        push_pixel(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_tvalid && shade_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ends [5];
    ends = '{16'h8000, 16'h7FFF, 16'h0000, 16'hC000, 16'h4000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // defaults after reset: corners, axes and center
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) push_pixel(ends[i], ends[(i + j) % 5]);
    push_pixel(16'h0400, 16'hFC00);
    push_random(90);
    drain();

    // camera at origin inside a huge sphere, zero far limit and threshold
    calm = 1;
    set_regs(16'd0, 16'd0, 16'd1, 8'd255, 15'h7FFF, 15'd0);
    push_random(20);
    drain();

    // single step, zero radius, coarse thresholds, far camera
    calm = 0;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 15'd0, 15'h7FFF);
    push_random(30);
    drain();

    // no marching at all
    set_regs(16'd25600, 16'd1678, 16'd1678, 8'd0, 15'd4096, 15'd4121);
    push_random(10);
    drain();

    set_regs(16'd1280, 16'd100, 16'd5000, 8'd60, 15'd6000, 15'd20000);
    push_random(60);
    drain();

    for (int k = 0; k < 3; k++) begin
      set_regs(16'($urandom), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 8'($urandom_range(1, 64)),
               15'($urandom), 15'($urandom));
      push_random(20);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
